// File: src/ga_pkg.sv
// Shared types, constants and helper functions for the grouped bitmap allocator.
// Depends on nothing; every other file refers to it by scoped names.
package ga_pkg;

    // Fixed geometry: 16 groups of up to 1024 blocks, 64-bit bitmap words
    localparam int MAX_GROUPS  = 16;
    localparam int MAX_BPG     = 1024;
    localparam int WORD_BITS   = 64;
    localparam int WORDS       = MAX_GROUPS * MAX_BPG / WORD_BITS;
    localparam int ADDR_W      = $clog2(WORDS);
    localparam int GRP_W       = $clog2(MAX_GROUPS);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int IDX_W       = $clog2(MAX_BPG);
    localparam int WIG_W       = IDX_W - BIT_W;

    // Field widths
    localparam int BLK_W       = 15;
    localparam int BPG_W       = 11;
    localparam int GC_W        = 5;

    // Configuration register reset values
    localparam logic [BPG_W-1:0] BPG_RST   = 11'd1024;
    localparam logic [GC_W-1:0]  GC_RST    = 5'd16;
    localparam logic [BLK_W-1:0] TOTAL_RST = 15'd16384;

    // Request actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef logic [WORD_BITS-1:0] t_word;

    // Result codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFREE  = 2'd1,
        ST_INVALID = 2'd2,
        ST_DOUBLE  = 2'd3
    } t_status;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_BPG   = 2'd0,
        CFG_GC    = 2'd1,
        CFG_FDB   = 2'd2,
        CFG_TOTAL = 2'd3
    } t_cfg_idx;

    // Bitmap memory request
    typedef struct packed {
        logic              re;
        logic              we;
        logic [ADDR_W-1:0] addr;
        t_word             wdata;
    } t_ram_req;

    // Position of the lowest set bit
    function automatic logic [BIT_W-1:0] lowest_set(input t_word v);
        logic [BIT_W-1:0] f;
        f = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (v[k]) f = BIT_W'(k);
        end
        return f;
    endfunction

    // Position of the highest set bit
    function automatic logic [BIT_W-1:0] highest_set(input t_word v);
        logic [BIT_W-1:0] f;
        f = '0;
        for (int k = 0; k < WORD_BITS; k++) begin
            if (v[k]) f = BIT_W'(k);
        end
        return f;
    endfunction

endpackage

// File: src/ga_div.sv
// Restoring divider, one quotient bit per cycle, splits a block offset
// into group and index. Depends on ga_pkg.
module ga_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ga_pkg::BLK_W-1:0]   i_dividend,
    input  logic [ga_pkg::BPG_W-1:0]   i_divisor,
    output logic                       o_done,
    output logic [ga_pkg::BLK_W-1:0]   o_quot,
    output logic [ga_pkg::BPG_W-1:0]   o_rem
);

    logic                       r_run;
    logic                       r_done;
    logic [3:0]                 r_cnt;
    logic [ga_pkg::BLK_W-1:0]   r_dvd;
    logic [ga_pkg::BPG_W-1:0]   r_div;
    logic [ga_pkg::BPG_W-1:0]   r_rem;
    logic [ga_pkg::BPG_W:0]     sh;
    logic                       ge;

    // One trial subtraction per cycle
    assign sh = {r_rem, r_dvd[ga_pkg::BLK_W-1]};
    assign ge = (sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 4'(ga_pkg::BLK_W - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in where dividend bits leave
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= {r_dvd[ga_pkg::BLK_W-2:0], ge};
            r_rem <= ge ? ga_pkg::BPG_W'(sh - {1'b0, r_div}) : sh[ga_pkg::BPG_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;
    assign o_rem  = r_rem;

endmodule

// File: src/ga_bitmap_ram.sv
// Allocation bitmap: single-port synchronous memory with registered read data,
// with a valid bit per word so reset reads as all free. Depends on ga_pkg.
module ga_bitmap_ram (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ga_pkg::t_ram_req i_req,
    output ga_pkg::t_word    o_rdata
);

    ga_pkg::t_word                 mem [ga_pkg::WORDS];
    logic [ga_pkg::WORDS-1:0]      r_valid;
    ga_pkg::t_word                 r_q;
    logic                          r_qv;

    // Word storage
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_q <= mem[i_req.addr];
        end
    end

    // Written-word flags; cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_qv    <= 1'b0;
        end else begin
            if (i_req.we) r_valid[i_req.addr] <= 1'b1;
            if (i_req.re) r_qv <= r_valid[i_req.addr];
        end
    end

    assign o_rdata = r_qv ? r_q : '0;

endmodule

// File: src/grouped_bitmap_block_allocator_unit.sv
// A valid free runs the divider, then one read-modify-write of its bitmap word; an invalid
// free is rejected at entry or after the divider. An allocate scans bitmap words one at a
// time through the single bitmap read port, upward then downward in each group tried;
// one item at a time, busy while working.
// Each result is shown for one cycle on o_done and cannot be stalled.
// Reset (synchronous, active low) marks every bitmap word free at once: no clearing pass.
module grouped_bitmap_block_allocator_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_action,
    input  logic [ga_pkg::BLK_W-1:0]  i_block_number,
    output logic                      o_done,
    output logic [1:0]                o_status,
    output logic [ga_pkg::BLK_W-1:0]  o_granted_block,
    output logic [ga_pkg::BLK_W-1:0]  o_free_blocks,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [ga_pkg::BLK_W-1:0]  i_cfg_data
);

    localparam int BW = ga_pkg::BLK_W;
    localparam int PW = ga_pkg::BPG_W;
    localparam int GW = ga_pkg::GRP_W;
    localparam int XW = ga_pkg::IDX_W;
    localparam int KW = ga_pkg::BIT_W;
    localparam int WW = ga_pkg::WIG_W;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_ENTRY  = 14'b00000000000010,
        S_DIV    = 14'b00000000000100,
        S_GCHK   = 14'b00000000001000,
        S_UP_RD  = 14'b00000000010000,
        S_UP_EV  = 14'b00000000100000,
        S_DN_RD  = 14'b00000001000000,
        S_DN_EV  = 14'b00000010000000,
        S_PICK   = 14'b00000100000000,
        S_NEXTG  = 14'b00001000000000,
        S_RMW_RD = 14'b00010000000000,
        S_RMW_WR = 14'b00100000000000,
        S_DONE   = 14'b01000000000000,
        S_SPARE  = 14'b10000000000000
    } t_state;

    // Configuration registers
    logic [PW-1:0] r_bpg_cfg;
    logic [4:0]    r_gc_cfg;
    logic          r_fdb;
    logic [BW-1:0] r_total;
    logic [PW-1:0] bpg_e;
    logic [4:0]    gc_e;
    logic [BW:0]   r_cap;

    // Sequencer state
    t_state               r_state, n_state;
    logic                 r_is_free, n_is_free;
    logic [BW-1:0]        r_bn, n_bn;
    logic [GW-1:0]        r_central, n_central;
    logic [GW-1:0]        r_g, n_g;
    logic signed [XW+1:0] r_h, n_h;
    logic [4:0]           r_d, n_d;
    logic                 r_side, n_side;
    logic                 r_low_out, n_low_out;
    logic                 r_high_out, n_high_out;
    logic [WW-1:0]        r_w, n_w;
    logic                 r_fu, n_fu;
    logic                 r_fd, n_fd;
    logic [XW-1:0]        r_iu, n_iu;
    logic [XW-1:0]        r_id, n_id;
    logic [XW-1:0]        r_idx, n_idx;
    logic [BW-1:0]        r_blk, n_blk;
    logic [PW-1:0]        r_cnt [ga_pkg::MAX_GROUPS];
    logic [PW-1:0]        n_cnt [ga_pkg::MAX_GROUPS];
    logic [BW-1:0]        r_used, n_used;
    ga_pkg::t_status      r_status, n_status;
    logic [BW-1:0]        r_granted, n_granted;

    // Output registers
    logic                 r_o_valid;
    logic [1:0]           r_o_status;
    logic [BW-1:0]        r_o_granted;
    logic [BW-1:0]        r_o_free;

    // Submodule signals
    ga_pkg::t_ram_req     ram_req;
    ga_pkg::t_word        rd;
    logic                 div_start;
    logic [BW-1:0]        div_dvd;
    logic                 div_done;
    logic [BW-1:0]        div_q;
    logic [PW-1:0]        div_r;

    // Combinational helpers
    logic [BW-1:0]        hint_c;
    logic signed [XW+1:0] bpg_s, s_up, e_dn;
    logic [PW-1:0]        bm1;
    logic [KW-1:0]        lo_k, hi_k;
    ga_pkg::t_word        mask, cand;
    logic                 any;
    logic [KW-1:0]        k_pos;
    t_state               dn_state;
    logic [WW-1:0]        dn_w;
    logic signed [XW+1:0] du, dd;
    logic                 take_up;
    logic [XW-1:0]        pick_idx;
    logic [BW:0]          pick_blk;
    logic [KW-1:0]        bitpos;
    ga_pkg::t_word        onehot;
    logic [5:0]           hi_grp;

    // Effective geometry
    assign bpg_e = (r_bpg_cfg == '0) ? PW'(1) :
                   ((r_bpg_cfg > PW'(ga_pkg::MAX_BPG)) ? PW'(ga_pkg::MAX_BPG) : r_bpg_cfg);
    assign gc_e  = (r_gc_cfg > 5'(ga_pkg::MAX_GROUPS)) ? 5'(ga_pkg::MAX_GROUPS) : r_gc_cfg;
    assign bpg_s = $signed({1'b0, bpg_e});
    assign bm1   = bpg_e - PW'(1);
    assign s_up  = r_h + 12'sd1;
    assign e_dn  = r_h - 12'sd1;

    // Configuration port
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpg_cfg <= ga_pkg::BPG_RST;
            r_gc_cfg  <= ga_pkg::GC_RST;
            r_fdb     <= 1'b0;
            r_total   <= ga_pkg::TOTAL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ga_pkg::CFG_BPG:   r_bpg_cfg <= i_cfg_data[PW-1:0];
                ga_pkg::CFG_GC:    r_gc_cfg  <= i_cfg_data[4:0];
                ga_pkg::CFG_FDB:   r_fdb     <= i_cfg_data[0];
                ga_pkg::CFG_TOTAL: r_total   <= i_cfg_data;
                default:           r_fdb     <= r_fdb;
            endcase
        end
    end

    // Capacity follows configuration, registered to keep the multiply off the result path
    always_ff @(posedge i_clk) begin
        logic [BW:0] lim, top;
        lim   = (BW+1)'(r_fdb) + (BW+1)'(gc_e * bpg_e);
        top   = ({1'b0, r_total} < lim) ? {1'b0, r_total} : lim;
        r_cap <= (top > (BW+1)'(r_fdb)) ? top - (BW+1)'(r_fdb) : '0;
    end

    ga_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (bpg_e),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    ga_bitmap_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .o_rdata (rd)
    );

    // Hint clamped to the last valid block
    assign hint_c  = (r_total != '0 && r_bn >= r_total) ? r_total - BW'(1) : r_bn;
    assign div_dvd = (r_is_free ? r_bn : hint_c) - BW'(r_fdb);

    // Word mask and free-bit search for the scan states
    always_comb begin
        if (r_state == S_UP_EV) begin
            lo_k = (r_w == s_up[XW-1:KW]) ? s_up[KW-1:0] : '0;
            hi_k = (r_w == bm1[XW-1:KW]) ? bm1[KW-1:0] : '1;
        end else begin
            lo_k = '0;
            hi_k = (r_w == e_dn[XW-1:KW]) ? e_dn[KW-1:0] : '1;
        end
        mask  = ({ga_pkg::WORD_BITS{1'b1}} << lo_k) &
                ({ga_pkg::WORD_BITS{1'b1}} >> (KW'(ga_pkg::WORD_BITS - 1) - hi_k));
        cand  = ~rd & mask;
        any   = |cand;
        k_pos = (r_state == S_UP_EV) ? ga_pkg::lowest_set(cand) : ga_pkg::highest_set(cand);
    end

    // Start of the downward scan
    always_comb begin
        if (e_dn >= 0) begin
            dn_state = S_DN_RD;
            dn_w     = e_dn[XW-1:KW];
        end else begin
            dn_state = S_PICK;
            dn_w     = r_w;
        end
    end

    // Nearest candidate, upward first on a tie
    assign du       = $signed({2'b00, r_iu}) - r_h;
    assign dd       = r_h - $signed({2'b00, r_id});
    assign take_up  = r_fu && (!r_fd || du <= dd);
    assign pick_idx = take_up ? r_iu : r_id;
    assign pick_blk = (BW+1)'(r_g * bpg_e) + (BW+1)'(r_fdb) + (BW+1)'(pick_idx);
    assign bitpos   = r_idx[KW-1:0];
    assign onehot   = ga_pkg::t_word'(1) << bitpos;
    assign hi_grp   = 6'(r_central) + 6'(r_d);

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_is_free  = r_is_free;
        n_bn       = r_bn;
        n_central  = r_central;
        n_g        = r_g;
        n_h        = r_h;
        n_d        = r_d;
        n_side     = r_side;
        n_low_out  = r_low_out;
        n_high_out = r_high_out;
        n_w        = r_w;
        n_fu       = r_fu;
        n_fd       = r_fd;
        n_iu       = r_iu;
        n_id       = r_id;
        n_idx      = r_idx;
        n_blk      = r_blk;
        n_cnt      = r_cnt;
        n_used     = r_used;
        n_status   = r_status;
        n_granted  = r_granted;
        div_start  = 1'b0;
        ram_req    = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_is_free  = (i_action == ga_pkg::ACT_FREE);
                    n_bn       = i_block_number;
                    n_d        = 5'd1;
                    n_side     = 1'b0;
                    n_low_out  = 1'b0;
                    n_high_out = 1'b0;
                    n_status   = ga_pkg::ST_OK;
                    n_granted  = '0;
                    n_state    = S_ENTRY;
                end
            end
            S_ENTRY: begin
                if (r_is_free) begin
                    if (r_bn >= r_total || r_bn < BW'(r_fdb)) begin
                        n_status = ga_pkg::ST_INVALID;
                        n_state  = S_DONE;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end else if (gc_e == '0) begin
                    n_status = ga_pkg::ST_NOFREE;
                    n_state  = S_DONE;
                end else if (hint_c < BW'(r_fdb)) begin
                    n_central = '0;
                    n_g       = '0;
                    n_h       = -12'sd1;
                    n_state   = S_GCHK;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (r_is_free) begin
                        if (div_q >= BW'(gc_e)) begin
                            n_status = ga_pkg::ST_INVALID;
                            n_state  = S_DONE;
                        end else begin
                            n_g     = div_q[GW-1:0];
                            n_idx   = div_r[XW-1:0];
                            n_state = S_RMW_RD;
                        end
                    end else begin
                        if (div_q >= BW'(gc_e)) begin
                            n_central = GW'(gc_e - 5'd1);
                            n_g       = GW'(gc_e - 5'd1);
                            n_h       = bpg_s - 12'sd1;
                        end else begin
                            n_central = div_q[GW-1:0];
                            n_g       = div_q[GW-1:0];
                            n_h       = $signed({1'b0, div_r});
                        end
                        n_state = S_GCHK;
                    end
                end
            end
            S_GCHK: begin
                n_fu = 1'b0;
                n_fd = 1'b0;
                if (r_cnt[r_g] >= bpg_e) begin
                    n_state = S_NEXTG;
                end else if (s_up < bpg_s) begin
                    n_w     = s_up[XW-1:KW];
                    n_state = S_UP_RD;
                end else begin
                    n_w     = dn_w;
                    n_state = dn_state;
                end
            end
            S_UP_RD, S_DN_RD: begin
                ram_req.re   = 1'b1;
                ram_req.addr = {r_g, r_w};
                n_state      = (r_state == S_UP_RD) ? S_UP_EV : S_DN_EV;
            end
            S_UP_EV: begin
                if (any) begin
                    n_fu    = 1'b1;
                    n_iu    = {r_w, k_pos};
                    n_w     = dn_w;
                    n_state = dn_state;
                end else if (r_w == bm1[XW-1:KW]) begin
                    n_w     = dn_w;
                    n_state = dn_state;
                end else begin
                    n_w     = r_w + WW'(1);
                    n_state = S_UP_RD;
                end
            end
            S_DN_EV: begin
                if (any) begin
                    n_fd    = 1'b1;
                    n_id    = {r_w, k_pos};
                    n_state = S_PICK;
                end else if (r_w == '0) begin
                    n_state = S_PICK;
                end else begin
                    n_w     = r_w - WW'(1);
                    n_state = S_DN_RD;
                end
            end
            S_PICK: begin
                if (!(r_fu || r_fd) || pick_blk >= (BW+1)'(r_total)) begin
                    n_state = S_NEXTG;
                end else begin
                    n_idx   = pick_idx;
                    n_blk   = pick_blk[BW-1:0];
                    n_state = S_RMW_RD;
                end
            end
            S_NEXTG: begin
                // Alternate lower and higher groups around the hint's group
                if (r_low_out && r_high_out) begin
                    n_status = ga_pkg::ST_NOFREE;
                    n_state  = S_DONE;
                end else if (!r_side) begin
                    n_side = 1'b1;
                    if (!r_low_out) begin
                        if (r_d <= 5'(r_central)) begin
                            n_g     = r_central - r_d[GW-1:0];
                            n_h     = bpg_s;
                            n_state = S_GCHK;
                        end else begin
                            n_low_out = 1'b1;
                        end
                    end
                end else begin
                    n_side = 1'b0;
                    n_d    = r_d + 5'd1;
                    if (!r_high_out) begin
                        if (hi_grp < 6'(gc_e)) begin
                            n_g     = hi_grp[GW-1:0];
                            n_h     = -12'sd1;
                            n_state = S_GCHK;
                        end else begin
                            n_high_out = 1'b1;
                        end
                    end
                end
            end
            S_RMW_RD: begin
                ram_req.re   = 1'b1;
                ram_req.addr = {r_g, r_idx[XW-1:KW]};
                n_state      = S_RMW_WR;
            end
            S_RMW_WR: begin
                ram_req.addr = {r_g, r_idx[XW-1:KW]};
                n_state      = S_DONE;
                if (r_is_free) begin
                    if (!rd[bitpos]) begin
                        n_status = ga_pkg::ST_DOUBLE;
                    end else begin
                        ram_req.we    = 1'b1;
                        ram_req.wdata = rd & ~onehot;
                        if (r_cnt[r_g] != '0) n_cnt[r_g] = r_cnt[r_g] - PW'(1);
                        if (r_used != '0) n_used = r_used - BW'(1);
                        n_status = ga_pkg::ST_OK;
                    end
                end else begin
                    ram_req.we    = 1'b1;
                    ram_req.wdata = rd | onehot;
                    n_cnt[r_g]    = r_cnt[r_g] + PW'(1);
                    n_used        = r_used + BW'(1);
                    n_status      = ga_pkg::ST_OK;
                    n_granted     = r_blk;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_o_valid <= 1'b0;
            for (int g = 0; g < ga_pkg::MAX_GROUPS; g++) r_cnt[g] <= '0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_cnt     <= n_cnt;
            r_o_valid <= (r_state == S_DONE);
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_is_free  <= n_is_free;
        r_bn       <= n_bn;
        r_central  <= n_central;
        r_g        <= n_g;
        r_h        <= n_h;
        r_d        <= n_d;
        r_side     <= n_side;
        r_low_out  <= n_low_out;
        r_high_out <= n_high_out;
        r_w        <= n_w;
        r_fu       <= n_fu;
        r_fd       <= n_fd;
        r_iu       <= n_iu;
        r_id       <= n_id;
        r_idx      <= n_idx;
        r_blk      <= n_blk;
        r_status   <= n_status;
        r_granted  <= n_granted;
    end

    // Result registers, free count from the updated used total
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            r_o_status  <= r_status;
            r_o_granted <= (r_status == ga_pkg::ST_OK && !r_is_free) ? r_granted : '0;
            r_o_free    <= (r_cap > {1'b0, r_used}) ? BW'(r_cap - {1'b0, r_used}) : '0;
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_o_valid;
    assign o_status        = r_o_status;
    assign o_granted_block = r_o_granted;
    assign o_free_blocks   = r_o_free;

    // Checks
    a_done_after_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_DONE))
        else $error("result strobe without completed item");

    a_grant_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ga_pkg::ST_OK) |-> (o_granted_block == '0))
        else $error("granted block on failed item");

    a_ram_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_req.we && ram_req.re))
        else $error("bitmap read and write in one cycle");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_req.we |-> $past(ram_req.re))
        else $error("bitmap write without prior read");

endmodule

// File: verif/tb_grouped_bitmap_block_allocator_unit.sv
// Self-checking testbench for grouped_bitmap_block_allocator_unit.
// Depends on src/ga_pkg.sv and the allocator RTL; models bitmap, counts and search order
// in SystemVerilog.
`timescale 1ns / 100ps

module tb_grouped_bitmap_block_allocator_unit;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 700;

    typedef struct {
        logic                     act;
        logic [ga_pkg::BLK_W-1:0] bn;
    } t_job;

    typedef struct {
        ga_pkg::t_status          status;
        logic [ga_pkg::BLK_W-1:0] granted;
        logic [ga_pkg::BLK_W-1:0] free_cnt;
    } t_answer;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic                     i_action;
    logic [ga_pkg::BLK_W-1:0] i_block_number;
    logic                     o_done;
    logic [1:0]               o_status;
    logic [ga_pkg::BLK_W-1:0] o_granted_block;
    logic [ga_pkg::BLK_W-1:0] o_free_blocks;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [1:0]               i_cfg_index;
    logic [ga_pkg::BLK_W-1:0] i_cfg_data;

    grouped_bitmap_block_allocator_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_block_number  (i_block_number),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_granted_block (o_granted_block),
        .o_free_blocks   (o_free_blocks),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Model state: registers, bitmap, per-group and total used counts
    int unsigned bpg_reg;
    int unsigned gc_reg;
    int unsigned fdb_reg;
    int unsigned total_reg;
    bit          used_map [ga_pkg::MAX_GROUPS*ga_pkg::MAX_BPG];
    int unsigned grp_used [ga_pkg::MAX_GROUPS];
    int unsigned used_sum;

    t_job    job_q [$];
    t_answer answer_q [$];
    t_job    drv_job;
    int      idle_pct;
    int      mismatches;
    int      n_alloc, n_free, n_nofree, n_invalid, n_double, n_checked;
    longint  cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_bpg();
        if (bpg_reg < 1) return 1;
        if (bpg_reg > ga_pkg::MAX_BPG) return ga_pkg::MAX_BPG;
        return bpg_reg;
    endfunction

    function automatic int unsigned eff_groups();
        return (gc_reg > ga_pkg::MAX_GROUPS) ? ga_pkg::MAX_GROUPS : gc_reg;
    endfunction

    function automatic bit is_used(int unsigned g, int unsigned i);
        if (g >= ga_pkg::MAX_GROUPS || i >= ga_pkg::MAX_BPG) return 1'b1;
        return used_map[g*ga_pkg::MAX_BPG + i];
    endfunction

    function automatic int unsigned free_now();
        longint lim, top, cap;
        lim = longint'(fdb_reg) + longint'(eff_groups()) * eff_bpg();
        top = (total_reg < lim) ? total_reg : lim;
        cap = (top > fdb_reg) ? top - fdb_reg : 0;
        return (cap > used_sum) ? int'((cap - used_sum) & 'h7FFF) : 0;
    endfunction

    // Outward search in one group from index h (h may sit just outside the group)
    function automatic bit scan_group(int unsigned g, int h, output int unsigned blk);
        int b, idx, up, dn;
        b = eff_bpg();
        idx = -1;
        blk = 0;
        if (g >= ga_pkg::MAX_GROUPS) return 1'b0;
        if (grp_used[g] >= b) return 1'b0;
        for (int d = 1; d <= b + 1; d++) begin
            up = h + d;
            dn = h - d;
            if (up < b && up >= 0 && !is_used(g, up)) begin
                idx = up;
                break;
            end
            if (dn >= 0 && dn < b && !is_used(g, dn)) begin
                idx = dn;
                break;
            end
        end
        if (idx < 0) return 1'b0;
        blk = g * b + fdb_reg + idx;
        if (blk >= total_reg) return 1'b0;
        used_map[g*ga_pkg::MAX_BPG + idx] = 1'b1;
        grp_used[g]++;
        used_sum++;
        return 1'b1;
    endfunction

    // Hint group first, then lower groups top down and higher groups bottom up
    function automatic bit alloc_near(int unsigned hint, output int unsigned blk);
        int unsigned b, gc, central;
        int h;
        bit low_out, high_out;
        b = eff_bpg();
        gc = eff_groups();
        low_out = 0;
        high_out = 0;
        blk = 0;
        if (gc == 0) return 1'b0;
        if (total_reg > 0 && hint >= total_reg) hint = total_reg - 1;
        if (hint < fdb_reg) begin
            central = 0;
            h = -1;
        end else begin
            central = (hint - fdb_reg) / b;
            h = (hint - fdb_reg) % b;
            if (central >= gc) begin
                central = gc - 1;
                h = b - 1;
            end
        end
        if (scan_group(central, h, blk)) return 1'b1;
        for (int unsigned d = 1; !(low_out && high_out); d++) begin
            if (!low_out) begin
                if (d > central) low_out = 1;
                else if (scan_group(central - d, b, blk)) return 1'b1;
            end
            if (!high_out) begin
                if (central + d >= gc) high_out = 1;
                else if (scan_group(central + d, -1, blk)) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic ga_pkg::t_status release_blk(int unsigned bn);
        int unsigned b, g, i;
        b = eff_bpg();
        if (bn >= total_reg || bn < fdb_reg) return ga_pkg::ST_INVALID;
        g = (bn - fdb_reg) / b;
        i = (bn - fdb_reg) % b;
        if (g >= eff_groups()) return ga_pkg::ST_INVALID;
        if (!is_used(g, i)) return ga_pkg::ST_DOUBLE;
        used_map[g*ga_pkg::MAX_BPG + i] = 1'b0;
        if (grp_used[g] > 0) grp_used[g]--;
        if (used_sum > 0) used_sum--;
        return ga_pkg::ST_OK;
    endfunction

    // Expected answer for one accepted item
    function automatic void predict_answer(logic act, logic [ga_pkg::BLK_W-1:0] bn);
        t_answer a;
        int unsigned g;
        a.granted = '0;
        if (act == ga_pkg::ACT_ALLOC) begin
            n_alloc++;
            if (alloc_near(bn, g)) begin
                a.status = ga_pkg::ST_OK;
                a.granted = g[ga_pkg::BLK_W-1:0];
            end else begin
                a.status = ga_pkg::ST_NOFREE;
            end
        end else begin
            n_free++;
            a.status = release_blk(bn);
        end
        case (a.status)
            ga_pkg::ST_NOFREE:  n_nofree++;
            ga_pkg::ST_INVALID: n_invalid++;
            ga_pkg::ST_DOUBLE:  n_double++;
            default: ;
        endcase
        a.free_cnt = free_now();
        answer_q.push_back(a);
    endfunction

    // Driver: start stays high until the block takes the item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_action <= ga_pkg::ACT_ALLOC;
            i_block_number <= '0;
        end else if (!start || !busy) begin
            if (start) predict_answer(i_action, i_block_number);
            if (job_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                drv_job = job_q.pop_front();
                start <= 1'b1;
                i_action <= drv_job.act;
                i_block_number <= drv_job.bn;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare each strobed result with the oldest expected answer
    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && o_done) begin
            if (answer_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result status=%0d granted=%0d free=%0d",
                             o_status, o_granted_block, o_free_blocks);
            end else begin
                a = answer_q.pop_front();
                n_checked++;
                if (o_status !== a.status || o_granted_block !== a.granted
                        || o_free_blocks !== a.free_cnt) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d exp st=%0d blk=%0d free=%0d got st=%0d blk=%0d free=%0d",
                                 n_checked, a.status, a.granted, a.free_cnt,
                                 o_status, o_granted_block, o_free_blocks);
                end
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic cfg_write(input ga_pkg::t_cfg_idx idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[ga_pkg::BLK_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            ga_pkg::CFG_BPG:   bpg_reg = val & 'h7FF;
            ga_pkg::CFG_GC:    gc_reg = val & 'h1F;
            ga_pkg::CFG_FDB:   fdb_reg = val & 'h1;
            ga_pkg::CFG_TOTAL: total_reg = val & 'h7FFF;
            default: ;
        endcase
    endtask

    task automatic set_geometry(int unsigned bpg, int unsigned gc, int unsigned fdb,
                                int unsigned total);
        cfg_write(ga_pkg::CFG_BPG, bpg);
        cfg_write(ga_pkg::CFG_GC, gc);
        cfg_write(ga_pkg::CFG_FDB, fdb);
        cfg_write(ga_pkg::CFG_TOTAL, total);
    endtask

    task automatic add_job(logic act, int unsigned bn);
        t_job j;
        j.act = act;
        j.bn = bn[ga_pkg::BLK_W-1:0];
        job_q.push_back(j);
    endtask

    // Mostly allocates and frees inside the live range, some full-range noise
    task automatic add_random_jobs(int n, int unsigned span);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 50) add_job(ga_pkg::ACT_ALLOC, $urandom_range(span));
            else if (r < 88) add_job(ga_pkg::ACT_FREE, $urandom_range(span));
            else add_job(1'($urandom_range(1)), $urandom_range(32767));
        end
    endtask

    // Sender holds off until every answer is back, then lets the block settle
    task automatic drain();
        do @(posedge i_clk); while (job_q.size() > 0 || start || answer_q.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int unsigned b, g, t;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_action = ga_pkg::ACT_ALLOC;
        i_block_number = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        bpg_reg = 32'(ga_pkg::BPG_RST);
        gc_reg = 32'(ga_pkg::GC_RST);
        fdb_reg = 0;
        total_reg = 32'(ga_pkg::TOTAL_RST);
        used_sum = 0;
        foreach (used_map[k]) used_map[k] = 1'b0;
        foreach (grp_used[k]) grp_used[k] = 0;
        idle_pct = 34;
        mismatches = 0;
        cycles = 0;
        n_alloc = 0; n_free = 0; n_nofree = 0; n_invalid = 0; n_double = 0; n_checked = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items at reset geometry: edges, clamped hints, bad and double frees
        add_job(ga_pkg::ACT_ALLOC, 0);
        add_job(ga_pkg::ACT_ALLOC, 0);
        add_job(ga_pkg::ACT_ALLOC, 1023);
        add_job(ga_pkg::ACT_ALLOC, 1024);
        add_job(ga_pkg::ACT_ALLOC, 16383);
        add_job(ga_pkg::ACT_ALLOC, 16384);
        add_job(ga_pkg::ACT_ALLOC, 32767);
        add_job(ga_pkg::ACT_FREE, 0);
        add_job(ga_pkg::ACT_FREE, 0);
        add_job(ga_pkg::ACT_FREE, 16384);
        add_job(ga_pkg::ACT_FREE, 32767);
        add_job(ga_pkg::ACT_FREE, 16383);
        add_job(ga_pkg::ACT_ALLOC, 5000);
        add_job(ga_pkg::ACT_FREE, 1023);
        add_job(ga_pkg::ACT_FREE, 1023);
        add_job(ga_pkg::ACT_ALLOC, 21845);
        add_job(ga_pkg::ACT_FREE, 10922);
        add_job(ga_pkg::ACT_ALLOC, 10922);
        drain();

        // Smallest geometry: one group, one valid block
        set_geometry(8, 1, 0, 1);
        add_job(ga_pkg::ACT_FREE, 0);
        add_job(ga_pkg::ACT_ALLOC, 0);
        add_job(ga_pkg::ACT_ALLOC, 0);
        add_random_jobs(40, 3);
        drain();

        // Many tiny groups, offset data area, no idle gaps at all
        idle_pct = 0;
        set_geometry(8, 16, 1, 16385);
        add_job(ga_pkg::ACT_ALLOC, 0);
        add_job(ga_pkg::ACT_FREE, 0);
        add_random_jobs(250, 140);
        drain();
        idle_pct = 34;

        // Total cuts the last group short: candidates past the end
        set_geometry(64, 4, 1, 200);
        add_random_jobs(250, 260);
        drain();

        // Largest geometry with offset
        set_geometry(1024, 16, 1, 16385);
        add_random_jobs(60, 16385);
        drain();

        // Random small geometries
        repeat (4) begin
            b = $urandom_range(8, 64);
            g = $urandom_range(1, 16);
            t = $urandom_range(1, b * g + 8);
            set_geometry(b, g, $urandom_range(1), t);
            add_random_jobs(145, t + 4);
            drain();
        end

        $display("covered %0d allocates and %0d frees over 9 geometries, %0d results checked",
                 n_alloc, n_free, n_checked);
        $display("no-free %0d, invalid %0d, double free %0d, mismatches %0d",
                 n_nofree, n_invalid, n_double, mismatches);
        if (mismatches == 0 && answer_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: grouped_bitmap_block_allocator_unit.f
src/ga_pkg.sv
src/ga_div.sv
src/ga_bitmap_ram.sv
src/grouped_bitmap_block_allocator_unit.sv
verif/tb_grouped_bitmap_block_allocator_unit.sv
